/* design/sta_pkg.sv */
// Package for the session table with idle aging.
// Table geometry, field widths, command/action/register codes and the config status struct.
// No dependencies; imported by sta_cfg, the top level and the testbench.
`timescale 1ns / 1ps

package sta_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int KEY_W     = 50;
  localparam int STAMP_W   = 32;
  localparam int TIMEOUT_W = 16;
  localparam int CMD_W     = 3;
  localparam int ACT_W     = 4;
  localparam int COUNT_W   = 6;
  localparam int ENTRY_W   = KEY_W + STAMP_W;

  // Blacklist and config port
  localparam int NUM_BLOCKED = 6;
  localparam int BLK_CNT_W   = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = KEY_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT    = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_OFFLOAD = 3'd2,
    CMD_QUERY   = 3'd3,
    CMD_TICK    = 3'd4,
    CMD_SWEEP   = 3'd5
  } cmd_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_REJECT  = 4'd0,
    ACT_UPDATE  = 4'd1,
    ACT_CREATE  = 4'd2,
    ACT_DELETE  = 4'd3,
    ACT_OFFLOAD = 4'd4,
    ACT_PRESENT = 4'd5,
    ACT_ABSENT  = 4'd6,
    ACT_FULL    = 4'd7,
    ACT_DONE    = 4'd8
  } act_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT   = 3'd0,
    REG_BLK_COUNT = 3'd1,
    REG_BLK_ID0   = 3'd2,
    REG_BLK_ID1   = 3'd3,
    REG_BLK_ID2   = 3'd4,
    REG_BLK_ID3   = 3'd5,
    REG_BLK_ID4   = 3'd6,
    REG_BLK_ID5   = 3'd7
  } cfg_reg_e;

  // Status from the config block to the sequencer
  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout;
    logic                 blocked;
  } cfg_stat_t;

endpackage

/* design/sta_ram.sv */
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* design/sta_cfg.sv */
// Configuration registers and blacklist match for the session table.
// Depends on sta_pkg.
`timescale 1ns / 1ps

module sta_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sta_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sta_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [sta_pkg::KEY_W-1:0]      key_i,
  output sta_pkg::cfg_stat_t             stat_o
);
  import sta_pkg::*;

  localparam int SLOT_W = $clog2(NUM_BLOCKED);

  logic [TIMEOUT_W-1:0] timeout_q;
  logic [BLK_CNT_W-1:0] blk_cnt_q;
  logic [KEY_W-1:0]     blk_id_q [NUM_BLOCKED];
  logic                 blocked;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_W'(60);
      blk_cnt_q <= '0;
      for (int i = 0; i < NUM_BLOCKED; i++) begin
        blk_id_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_TIMEOUT:   timeout_q <= cfg_data_i[TIMEOUT_W-1:0];
        REG_BLK_COUNT: blk_cnt_q <= cfg_data_i[BLK_CNT_W-1:0];
        REG_BLK_ID0, REG_BLK_ID1, REG_BLK_ID2,
        REG_BLK_ID3, REG_BLK_ID4, REG_BLK_ID5: begin
          blk_id_q[SLOT_W'(cfg_idx_i - REG_BLK_ID0)] <= cfg_data_i[KEY_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Blacklist compare; a count above six covers all slots anyway
  always_comb begin
    blocked = 1'b0;
    for (int i = 0; i < NUM_BLOCKED; i++) begin
      if ((BLK_CNT_W'(i) < blk_cnt_q) && (blk_id_q[i] == key_i)) begin
        blocked = 1'b1;
      end
    end
  end

  assign stat_o.timeout = timeout_q;
  assign stat_o.blocked = blocked;

endmodule

/* design/session_table_with_aging.sv */
// Session table with idle aging: top level and table sequencer.
// Depends on sta_pkg, sta_ram (key/stamp store) and sta_cfg (registers, blacklist).
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries a command and a subscriber id.
//   Output channel (out_valid_o/out_ready_i) carries action, id, idle seconds,
//   removed count and a last flag marking the final result of a command.
//   Config port: one register per cycle, user writes only while idle; not enforced.
// Timing:
//   Tick and unknown commands are handled in S_IDLE and give no result.
//   Init, remove, offload and query walk the table one entry per cycle through
//   the RAM read port, then S_RESP registers the result once the output is free
//   (an offload of an absent key gives none); the next command is taken in S_IDLE.
//   A sweep walks the same way, emitting each expired entry as it is found, then
//   the done marker from S_FIN, each result waiting for a free output.
// Reset: all sessions invalid, seconds counter zero, registers at defaults.
// Stall: one output register; a held result stops the walk at the entry that
//   needs to emit, and a new command is taken only after the walk ends.
`timescale 1ns / 1ps

module session_table_with_aging (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [sta_pkg::CMD_W-1:0]      command_i,
  input  logic [sta_pkg::KEY_W-1:0]      subscriber_id_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sta_pkg::ACT_W-1:0]      action_o,
  output logic [sta_pkg::KEY_W-1:0]      result_id_o,
  output logic [sta_pkg::STAMP_W-1:0]    idle_seconds_o,
  output logic [sta_pkg::COUNT_W-1:0]    removed_count_o,
  output logic                           last_o,
  input  logic                           cfg_we_i,
  input  logic [sta_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sta_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sta_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP,
    S_FIN
  } state_e;

  state_e                 state_q, state_d;
  cmd_e                   cmd_q, cmd_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [STAMP_W-1:0]     now_q, now_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]       scan_q, scan_d;
  logic                   chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]       chk_idx_q, chk_idx_d;
  logic                   match_q, match_d;
  logic [IDX_W-1:0]       match_idx_q, match_idx_d;
  logic                   free_q, free_d;
  logic [IDX_W-1:0]       free_idx_q, free_idx_d;
  logic [COUNT_W-1:0]     count_q, count_d;

  logic                   out_valid_q, out_valid_d;
  act_e                   out_act_q, out_act_d;
  logic [KEY_W-1:0]       out_id_q, out_id_d;
  logic [STAMP_W-1:0]     out_idle_q, out_idle_d;
  logic [COUNT_W-1:0]     out_cnt_q, out_cnt_d;
  logic                   out_last_q, out_last_d;

  // RAM and config interface
  logic                   ram_we, ram_re;
  logic [IDX_W-1:0]       ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;
  cfg_stat_t              cfg_stat;

  logic [KEY_W-1:0]       rd_key;
  logic [STAMP_W-1:0]     rd_stamp, chk_idle;
  logic                   chk_live, key_hit, sweep_hit, out_free, stall, ld;

  sta_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .key_i      (key_q),
    .stat_o     (cfg_stat)
  );

  sta_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({key_q, now_q}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Entry checked this cycle
  assign rd_key    = ram_rdata[ENTRY_W-1:STAMP_W];
  assign rd_stamp  = ram_rdata[STAMP_W-1:0];
  assign chk_idle  = now_q - rd_stamp;
  assign chk_live  = chk_vld_q && valid_q[chk_idx_q];
  assign key_hit   = chk_live && (rd_key == key_q);
  assign sweep_hit = chk_live && (cmd_q == CMD_SWEEP) &&
                     (chk_idle >= {{(STAMP_W-TIMEOUT_W){1'b0}}, cfg_stat.timeout});
  assign out_free  = !out_valid_q || out_ready_i;
  assign stall     = sweep_hit && !out_free;

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    now_d       = now_q;
    valid_d     = valid_q;
    scan_d      = scan_q;
    chk_vld_d   = chk_vld_q;
    chk_idx_d   = chk_idx_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    count_d     = count_q;
    ram_we      = 1'b0;
    ram_waddr   = match_idx_q;
    ram_re      = 1'b0;
    ram_raddr   = scan_q[IDX_W-1:0];
    ld          = 1'b0;
    out_act_d   = out_act_q;
    out_id_d    = key_q;
    out_idle_d  = '0;
    out_cnt_d   = '0;
    out_last_d  = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d     = cmd_e'(command_i);
          key_d     = subscriber_id_i;
          scan_d    = '0;
          chk_vld_d = 1'b0;
          match_d   = 1'b0;
          free_d    = 1'b0;
          count_d   = '0;
          case (cmd_e'(command_i))
            CMD_TICK: now_d = now_q + STAMP_W'(1);
            CMD_INIT, CMD_REMOVE, CMD_OFFLOAD, CMD_QUERY, CMD_SWEEP: state_d = S_SCAN;
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (!stall) begin
          // Issue the next read
          if (scan_q < CNT_W'(TABLE_DEPTH)) begin
            ram_re    = 1'b1;
            chk_idx_d = scan_q[IDX_W-1:0];
            chk_vld_d = 1'b1;
            scan_d    = scan_q + CNT_W'(1);
          end else begin
            chk_vld_d = 1'b0;
          end
          // Check the entry held on the RAM read data
          if (cmd_q == CMD_SWEEP) begin
            if (sweep_hit) begin
              valid_d[chk_idx_q] = 1'b0;
              count_d    = count_q + COUNT_W'(1);
              ld         = 1'b1;
              out_act_d  = ACT_DELETE;
              out_id_d   = rd_key;
              out_idle_d = chk_idle;
              out_last_d = 1'b0;
            end
          end else if (chk_vld_q) begin
            if (key_hit && !match_q) begin
              match_d     = 1'b1;
              match_idx_d = chk_idx_q;
            end
            if (!valid_q[chk_idx_q] && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = chk_idx_q;
            end
          end
        end
        if ((scan_q == CNT_W'(TABLE_DEPTH)) && !chk_vld_q) begin
          state_d = (cmd_q == CMD_SWEEP) ? S_FIN : S_RESP;
        end
      end

      S_RESP: begin
        case (cmd_q)
          CMD_INIT: begin
            if (out_free) begin
              ld      = 1'b1;
              state_d = S_IDLE;
              if (cfg_stat.blocked) begin
                out_act_d = ACT_REJECT;
              end else if (match_q) begin
                ram_we    = 1'b1;
                out_act_d = ACT_UPDATE;
              end else if (free_q) begin
                ram_we              = 1'b1;
                ram_waddr           = free_idx_q;
                valid_d[free_idx_q] = 1'b1;
                out_act_d           = ACT_CREATE;
              end else begin
                out_act_d = ACT_FULL;
              end
            end
          end
          CMD_REMOVE: begin
            if (out_free) begin
              ld        = 1'b1;
              out_act_d = ACT_DELETE;
              state_d   = S_IDLE;
              if (match_q) begin
                valid_d[match_idx_q] = 1'b0;
              end
            end
          end
          CMD_OFFLOAD: begin
            if (!match_q) begin
              state_d = S_IDLE;
            end else if (out_free) begin
              ld                   = 1'b1;
              out_act_d            = ACT_OFFLOAD;
              valid_d[match_idx_q] = 1'b0;
              state_d              = S_IDLE;
            end
          end
          CMD_QUERY: begin
            if (out_free) begin
              ld        = 1'b1;
              out_act_d = match_q ? ACT_PRESENT : ACT_ABSENT;
              state_d   = S_IDLE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end

      S_FIN: begin
        if (out_free) begin
          ld        = 1'b1;
          out_act_d = ACT_DONE;
          out_id_d  = '0;
          out_cnt_d = count_q;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    out_valid_d = ld || (out_valid_q && !out_ready_i);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      valid_q     <= '0;
      scan_q      <= '0;
      chk_vld_q   <= 1'b0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      valid_q     <= valid_d;
      scan_q      <= scan_d;
      chk_vld_q   <= chk_vld_d;
      match_q     <= match_d;
      free_q      <= free_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    key_q       <= key_d;
    chk_idx_q   <= chk_idx_d;
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    if (ld) begin
      out_act_q  <= out_act_d;
      out_id_q   <= out_id_d;
      out_idle_q <= out_idle_d;
      out_cnt_q  <= out_cnt_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign action_o        = out_act_q;
  assign result_id_o     = out_id_q;
  assign idle_seconds_o  = out_idle_q;
  assign removed_count_o = out_cnt_q;
  assign last_o          = out_last_q;

endmodule

/* tb/session_table_with_aging_tb.sv */
// Self-checking testbench for session_table_with_aging: directed cases, then random phases.
// A tracker class mirrors the session table, blacklist and seconds counter to predict actions.
// Depends on sta_pkg and the session_table_with_aging RTL.
`timescale 1ns / 1ps

module session_table_with_aging_tb;
  import sta_pkg::*;

  localparam logic [KEY_W-1:0]  KEY_MAX      = '1;
  localparam logic [KEY_W-1:0]  KEY_15DIGITS = 50'd999999999999999;
  localparam logic [CMD_W-1:0]  CMD_UNUSED_A = 3'd6;
  localparam logic [CMD_W-1:0]  CMD_UNUSED_B = 3'd7;
  localparam int                POOL_SIZE    = 48;
  localparam int                MAX_IDLE     = 19;
  localparam int                HOLD_CYCLES  = 400;

  typedef struct packed {
    act_e                 action;
    logic [KEY_W-1:0]     id;
    logic [STAMP_W-1:0]   idle;
    logic [COUNT_W-1:0]   count;
    logic                 last;
  } session_result_t;

  // Mirror of the session table; computes the actions each command should produce
  class session_tracker;
    logic [TIMEOUT_W-1:0] timeout;
    logic [BLK_CNT_W-1:0] blk_count;
    logic [KEY_W-1:0]     blk_id [NUM_BLOCKED];
    bit                   valid [TABLE_DEPTH];
    logic [KEY_W-1:0]     key [TABLE_DEPTH];
    logic [STAMP_W-1:0]   stamp [TABLE_DEPTH];
    logic [STAMP_W-1:0]   now;
    session_result_t      awaited [$];
    int                   errors;

    function new();
      timeout   = 16'd60;
      blk_count = '0;
      foreach (blk_id[i]) blk_id[i] = '0;
      foreach (valid[i]) begin
        valid[i] = 1'b0;
        key[i]   = '0;
        stamp[i] = '0;
      end
      now    = '0;
      errors = 0;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function void write_register(cfg_reg_e r, logic [CFG_DATA_W-1:0] d);
      case (r)
        REG_TIMEOUT:   timeout = d[TIMEOUT_W-1:0];
        REG_BLK_COUNT: blk_count = d[BLK_CNT_W-1:0];
        default:       blk_id[int'(r) - int'(REG_BLK_ID0)] = d[KEY_W-1:0];
      endcase
    endfunction

    function void push(act_e a, logic [KEY_W-1:0] k, logic [STAMP_W-1:0] idle,
                       logic [COUNT_W-1:0] cnt, logic lst);
      session_result_t r;
      r.action = a;
      r.id     = k;
      r.idle   = idle;
      r.count  = cnt;
      r.last   = lst;
      awaited.insert(awaited.size(), r);
    endfunction

    // Called once per accepted command transfer
    function void apply_command(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k);
      int i;
      int slot;
      int free;
      int n;
      bit hit_blk;
      logic [STAMP_W-1:0] idle;
      slot = -1;
      free = -1;
      for (i = TABLE_DEPTH - 1; i >= 0; i--) begin
        if (valid[i] && key[i] == k) slot = i;
        if (!valid[i]) free = i;
      end
      n = (blk_count > NUM_BLOCKED) ? NUM_BLOCKED : int'(blk_count);
      hit_blk = 1'b0;
      for (i = 0; i < n; i++)
        if (blk_id[i] == k) hit_blk = 1'b1;
      case (c)
        CMD_INIT: begin
          if (hit_blk) begin
            push(ACT_REJECT, k, '0, '0, 1'b1);
          end else if (slot >= 0) begin
            stamp[slot] = now;
            push(ACT_UPDATE, k, '0, '0, 1'b1);
          end else if (free < 0) begin
            push(ACT_FULL, k, '0, '0, 1'b1);
          end else begin
            valid[free] = 1'b1;
            key[free]   = k;
            stamp[free] = now;
            push(ACT_CREATE, k, '0, '0, 1'b1);
          end
        end
        CMD_REMOVE: begin
          if (slot >= 0) valid[slot] = 1'b0;
          push(ACT_DELETE, k, '0, '0, 1'b1);
        end
        CMD_OFFLOAD: begin
          if (slot >= 0) begin
            valid[slot] = 1'b0;
            push(ACT_OFFLOAD, k, '0, '0, 1'b1);
          end
        end
        CMD_QUERY: begin
          if (slot >= 0) push(ACT_PRESENT, k, '0, '0, 1'b1);
          else push(ACT_ABSENT, k, '0, '0, 1'b1);
        end
        CMD_TICK: now = now + 1'b1;
        CMD_SWEEP: begin
          n = 0;
          for (i = 0; i < TABLE_DEPTH; i++) begin
            if (valid[i]) begin
              idle = now - stamp[i];
              if (idle >= STAMP_W'(timeout)) begin
                valid[i] = 1'b0;
                push(ACT_DELETE, key[i], idle, '0, 1'b0);
                n++;
              end
            end
          end
          push(ACT_DONE, '0, '0, COUNT_W'(n), 1'b1);
        end
        default: ;  // unknown codes are dropped
      endcase
    endfunction

    function void check_result(session_result_t got);
      session_result_t exp;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result: action %0d id %0h idle %0d count %0d last %0b",
                 $realtime, got.action, got.id, got.idle, got.count, got.last);
        errors++;
        return;
      end
      exp = awaited.pop_front();
      if (got !== exp) begin
        $display("%0t: result mismatch: expected action %0d id %0h idle %0d count %0d last %0b",
                 $realtime, exp.action, exp.id, exp.idle, exp.count, exp.last);
        $display("%0t:                  actual   action %0d id %0h idle %0d count %0d last %0b",
                 $realtime, got.action, got.id, got.idle, got.count, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [CMD_W-1:0]      command_i;
  logic [KEY_W-1:0]      subscriber_id_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [ACT_W-1:0]      action_o;
  logic [KEY_W-1:0]      result_id_o;
  logic [STAMP_W-1:0]    idle_seconds_o;
  logic [COUNT_W-1:0]    removed_count_o;
  logic                  last_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  session_tracker   tracker;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  bit               burst;         // no idling on either side while set
  bit               hold_request;  // asks the receiver for one long hold-off

  session_table_with_aging uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("session_table_with_aging test failed");
    $finish;
  end

  function automatic logic [KEY_W-1:0] rand_key();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[KEY_W-1:0];
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(int pool_n);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return key_pool[$urandom_range(0, pool_n - 1)];
    if (r < 90) return tracker.blk_id[$urandom_range(0, NUM_BLOCKED - 1)];
    return rand_key();
  endfunction

  // One command transfer, after a random gap
  task automatic send_item(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k);
    int gap;
    gap = burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= c;
    subscriber_id_i <= k;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.apply_command(c, k);
  endtask

  // Wait until every awaited action has come out and the block has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= r;
    cfg_data_i <= d;
    @(posedge clk_i);
    tracker.write_register(r, d);
  endtask

  // Writes every register; unused upper data bits carry junk
  task automatic configure(logic [TIMEOUT_W-1:0] tmo, logic [BLK_CNT_W-1:0] cnt,
                           input logic [KEY_W-1:0] ids [NUM_BLOCKED]);
    logic [KEY_W-1:0] junk;
    int i;
    junk = rand_key();
    write_reg(REG_TIMEOUT, {junk[KEY_W-1:TIMEOUT_W], tmo});
    junk = rand_key();
    write_reg(REG_BLK_COUNT, {junk[KEY_W-1:BLK_CNT_W], cnt});
    for (i = 0; i < NUM_BLOCKED; i++)
      write_reg(cfg_reg_e'(int'(REG_BLK_ID0) + i), ids[i]);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic new_setting(logic [TIMEOUT_W-1:0] tmo, logic [BLK_CNT_W-1:0] cnt,
                             int pool_n);
    logic [KEY_W-1:0] ids [NUM_BLOCKED];
    int i;
    for (i = 0; i < NUM_BLOCKED; i++)
      ids[i] = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, pool_n - 1)]
                                          : rand_key();
    configure(tmo, cnt, ids);
  endtask

  task automatic run_phase(int items, int init_pct, int pool_n);
    int j;
    int r;
    logic [CMD_W-1:0] c;
    for (j = 0; j < items; j++) begin
      r = $urandom_range(0, 99);
      if (r < init_pct) begin
        c = CMD_INIT;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 14) c = CMD_REMOVE;
        else if (r < 30) c = CMD_OFFLOAD;
        else if (r < 48) c = CMD_QUERY;
        else if (r < 80) c = CMD_TICK;
        else if (r < 94) c = CMD_SWEEP;
        else c = $urandom_range(0, 1) ? CMD_UNUSED_A : CMD_UNUSED_B;
      end
      send_item(c, pick_key(pool_n));
    end
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    session_result_t got;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = burst ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.action = act_e'(action_o);
      got.id     = result_id_o;
      got.idle   = idle_seconds_o;
      got.count  = removed_count_o;
      got.last   = last_o;
      tracker.check_result(got);
    end
  end

  // Stimulus
  initial begin
    logic [KEY_W-1:0] ids [NUM_BLOCKED];
    int i;
    in_valid_i      <= 1'b0;
    command_i       <= CMD_INIT;
    subscriber_id_i <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= REG_TIMEOUT;
    cfg_data_i      <= '0;
    rst_ni          <= 1'b0;
    burst        = 1'b0;
    hold_request = 1'b0;
    tracker = new();
    key_pool[0] = '0;
    key_pool[1] = KEY_MAX;
    key_pool[2] = KEY_15DIGITS;
    for (i = 3; i < POOL_SIZE; i++)
      key_pool[i] = (i < 10) ? KEY_W'($urandom_range(1, 1000)) : rand_key();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset settings: create, update, lookups, absent remove/offload
    send_item(CMD_INIT, '0);                  // key zero is fine with an empty blacklist
    send_item(CMD_INIT, KEY_MAX);
    send_item(CMD_INIT, KEY_15DIGITS);
    send_item(CMD_INIT, '0);                  // refresh
    send_item(CMD_TICK, KEY_MAX);
    send_item(CMD_TICK, '0);
    send_item(CMD_QUERY, '0);
    send_item(CMD_QUERY, 50'd5);
    send_item(CMD_REMOVE, 50'd5);             // absent key still answers delete
    send_item(CMD_OFFLOAD, 50'd5);            // absent key: silent
    send_item(CMD_OFFLOAD, KEY_MAX);
    send_item(CMD_UNUSED_A, KEY_MAX);
    send_item(CMD_UNUSED_B, '0);
    send_item(CMD_SWEEP, '0);                 // nothing old enough: done marker only
    send_item(CMD_REMOVE, '0);
    settle();

    // Zero timeout, count above six, blacklist extremes
    ids[0] = KEY_MAX;
    ids[1] = '0;
    ids[2] = 50'd17;
    ids[3] = 50'd18;
    ids[4] = 50'd19;
    ids[5] = KEY_15DIGITS;
    configure('0, 3'd7, ids);
    send_item(CMD_INIT, KEY_MAX);
    send_item(CMD_INIT, '0);
    send_item(CMD_INIT, KEY_15DIGITS);        // last slot still checked
    send_item(CMD_INIT, 50'd42);
    send_item(CMD_TICK, '0);
    send_item(CMD_SWEEP, KEY_MAX);            // sweeps both live sessions in slot order
    send_item(CMD_SWEEP, '0);
    settle();

    // Random phases
    new_setting(16'd5, 3'd3, 20);
    run_phase(70, 45, 20);
    settle();
    new_setting('0, '0, 24);
    burst = 1'b1;
    run_phase(60, 40, 24);
    burst = 1'b0;
    settle();
    // Init-heavy with a huge timeout fills the table
    new_setting(16'hFFFF, 3'd7, POOL_SIZE);
    hold_request = 1'b1;
    run_phase(80, 75, POOL_SIZE);
    settle();
    new_setting(16'd3, 3'd6, 40);
    run_phase(70, 40, 40);
    settle();
    new_setting(TIMEOUT_W'($urandom), BLK_CNT_W'($urandom_range(0, 7)), 32);
    run_phase(40, 50, 32);
    settle();
    new_setting(16'd1, BLK_CNT_W'($urandom_range(0, 7)), 16);
    run_phase(50, 45, 16);
    burst = 1'b1;
    run_phase(50, 45, 16);
    burst = 1'b0;
    settle();

    if (tracker.errors == 0) begin
      $display("session_table_with_aging test passed");
    end else begin
      $display("session_table_with_aging test failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/sta_pkg.sv
design/sta_ram.sv
design/sta_cfg.sv
design/session_table_with_aging.sv
tb/session_table_with_aging_tb.sv
